// ===== rtl/i2cmbs_pkg.sv =====
// Package for the I2C master bit sequencer: request/result structs, command
// codes, sequencer state struct and sequence length table.
// No dependencies; imported by every module of the block.
package i2cmbs_pkg;

  // Bits per transferred byte
  localparam int unsigned DataBits = 8;
  // Step counter width, holds the longest sequence (read: 1 + 3 * DataBits)
  localparam int unsigned StepW = 5;
  // Phase counter width, one clock period is three steps
  localparam int unsigned PhaseW = 2;

  // Command codes carried in the func field
  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4,
    OP_SACK  = 3'd5,
    OP_RACK  = 3'd6
  } op_e;

  // Input request
  typedef struct packed {
    logic [2:0]          func;
    logic [DataBits-1:0] data_byte;
    logic                ack_level;
    logic                sda_in;
  } req_t;

  // Result of one request
  typedef struct packed {
    logic                scl_level;
    logic                sda_level;
    logic                busy_res;
    logic                done_res;
    logic [DataBits-1:0] rx_byte;
    logic                rx_ack;
    logic                status;
  } res_t;

  // Sequencer state; op == OP_TICK means idle
  typedef struct packed {
    logic                scl;
    logic                sda;
    op_e                 op;
    logic [StepW-1:0]    step;
    logic [PhaseW-1:0]   phase;
    logic [DataBits-1:0] tx;
    logic [DataBits-1:0] rx;
    logic                ack;
  } state_t;

  // Number of ticks in each command sequence
  function automatic logic [StepW-1:0] seq_len(op_e op);
    logic [StepW-1:0] len;
    unique case (op)
      OP_START: len = StepW'(4);
      OP_STOP:  len = StepW'(3);
      OP_WRITE: len = StepW'(3 * DataBits);
      OP_READ:  len = StepW'(1 + 3 * DataBits);
      OP_SACK:  len = StepW'(3);
      OP_RACK:  len = StepW'(4);
      default:  len = '0;
    endcase
    return len;
  endfunction

endpackage

// ===== rtl/i2cmbs_in_stage.sv =====
// Input register of the I2C master bit sequencer: holds one request until
// the step logic takes it. Depends on i2cmbs_pkg.
module i2cmbs_in_stage import i2cmbs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_req_i,
  input  logic take_i,
  output logic valid_o,
  output req_t req_o
);

  logic valid_q;
  req_t req_q;

  // Accept when empty or when the held request leaves this cycle
  assign in_ready_o = !valid_q || take_i;

  // Hold valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (in_ready_o) begin
      valid_q <= in_valid_i;
    end
  end

  // Load request payload
  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      req_q <= in_req_i;
    end
  end

  assign valid_o = valid_q;
  assign req_o   = req_q;

endmodule

// ===== rtl/i2cmbs_step.sv =====
// Step logic of the I2C master bit sequencer: from the current state and one
// request, form the next state and the result. Depends on i2cmbs_pkg.
module i2cmbs_step import i2cmbs_pkg::*; (
  input  state_t st_i,
  input  req_t   req_i,
  output state_t st_o,
  output res_t   res_o
);

  logic [StepW-1:0]  step_inc;
  logic [StepW-1:0]  len;
  logic [PhaseW-1:0] phase_inc;
  logic              done;
  logic              status;
  logic              busy;
  logic              is_cmd;
  state_t            nx;
  state_t            tk;

  assign busy      = (st_i.op != OP_TICK);
  assign is_cmd    = (req_i.func >= 3'(OP_START)) && (req_i.func <= 3'(OP_RACK));
  assign step_inc  = st_i.step + StepW'(1);
  assign len       = seq_len(st_i.op);
  assign phase_inc = (st_i.phase == PhaseW'(2)) ? '0 : st_i.phase + PhaseW'(1);

  // Perform one pin action of the active sequence
  always_comb begin
    tk      = st_i;
    tk.step = step_inc;
    unique case (st_i.op)
      OP_START: begin
        if (st_i.step == StepW'(0))      tk.sda = 1'b1;
        else if (st_i.step == StepW'(1)) tk.scl = 1'b1;
        else if (st_i.step == StepW'(2)) tk.sda = 1'b0;
        else                             tk.scl = 1'b0;
      end
      OP_STOP: begin
        if (st_i.step == StepW'(0))      tk.sda = 1'b0;
        else if (st_i.step == StepW'(1)) tk.scl = 1'b1;
        else                             tk.sda = 1'b1;
      end
      OP_WRITE: begin
        tk.phase = phase_inc;
        if (st_i.phase == PhaseW'(0)) begin
          tk.sda = st_i.tx[DataBits-1];
        end else if (st_i.phase == PhaseW'(1)) begin
          tk.scl = 1'b1;
        end else begin
          tk.scl = 1'b0;
          tk.tx  = {st_i.tx[DataBits-2:0], 1'b0};
        end
      end
      OP_READ: begin
        if (st_i.step == StepW'(0)) begin
          tk.sda = 1'b1;
        end else begin
          tk.phase = phase_inc;
          if (st_i.phase == PhaseW'(0))      tk.scl = 1'b1;
          else if (st_i.phase == PhaseW'(1)) tk.rx  = {st_i.rx[DataBits-2:0], req_i.sda_in};
          else                               tk.scl = 1'b0;
        end
      end
      OP_SACK: begin
        if (st_i.step == StepW'(0))      tk.sda = st_i.tx[0];
        else if (st_i.step == StepW'(1)) tk.scl = 1'b1;
        else                             tk.scl = 1'b0;
      end
      OP_RACK: begin
        if (st_i.step == StepW'(0))      tk.sda = 1'b1;
        else if (st_i.step == StepW'(1)) tk.scl = 1'b1;
        else if (st_i.step == StepW'(2)) tk.ack = req_i.sda_in;
        else                             tk.scl = 1'b0;
      end
      default: ;
    endcase
    // Drop back to idle after the final step
    if (step_inc >= len) begin
      tk.op    = OP_TICK;
      tk.step  = '0;
      tk.phase = '0;
    end
  end

  // Select between command latch, tick step and no change
  always_comb begin
    nx     = st_i;
    done   = 1'b0;
    status = 1'b0;
    if (is_cmd) begin
      if (busy) begin
        status = 1'b1;
      end else begin
        nx.op    = op_e'(req_i.func);
        nx.step  = '0;
        nx.phase = '0;
        if (req_i.func == 3'(OP_WRITE)) begin
          nx.tx = req_i.data_byte;
        end else if (req_i.func == 3'(OP_SACK)) begin
          nx.tx = DataBits'(req_i.ack_level);
        end else if (req_i.func == 3'(OP_READ)) begin
          nx.rx = '0;
        end
      end
    end else if ((req_i.func == 3'(OP_TICK)) && busy) begin
      nx   = tk;
      done = (step_inc >= len);
    end
  end

  assign st_o = nx;

  // Form the result from the updated state
  always_comb begin
    res_o.scl_level = nx.scl;
    res_o.sda_level = nx.sda;
    res_o.busy_res  = (nx.op != OP_TICK);
    res_o.done_res  = done;
    res_o.rx_byte   = nx.rx;
    res_o.rx_ack    = nx.ack;
    res_o.status    = status;
  end

endmodule

// ===== rtl/i2c_master_bit_sequencer_core.sv =====
// I2C master bit sequencer, top level.
// Request channel (in_valid_i/in_ready_o/in_req_i) carries either a command
// (start, stop, write byte, read byte, send ack, receive ack) or a tick.
// A command is latched while idle and moves no pin; a command that arrives
// while a sequence runs is rejected with status 1. Each tick in a sequence
// performs one pin action: drive SCL, drive SDA, or sample in_req_i.sda_in.
// Result channel (out_valid_o/out_ready_i/out_res_o) returns exactly one
// result per request: SCL/SDA drive levels, busy, done, received byte,
// received ack and status.
// Path: an accepted request lands in the input register, and the step
// logic's output is then loaded into the result register when it is free.
// Throughput: one request per cycle while results are taken; the step logic
// is combinational, so consecutive ticks follow back to back.
// Reset: SCL and SDA released (1), sequencer idle, bytes cleared, ack 1.
// Stall: while out_ready_i is low the result holds; one more request waits
// in the input register, after which in_ready_o drops.
// Depends on i2cmbs_pkg, i2cmbs_in_stage, i2cmbs_step.
module i2c_master_bit_sequencer_core import i2cmbs_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output res_t out_res_o
);

  logic   req_valid;
  req_t   req;
  logic   fire;
  logic   out_valid_q;
  res_t   res_q;
  res_t   res_d;
  state_t st_q;
  state_t st_d;

  // Process the held request when the result register is free
  assign fire = req_valid && (!out_valid_q || out_ready_i);

  i2cmbs_in_stage u_in_stage (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_req_i   (in_req_i),
    .take_i     (fire),
    .valid_o    (req_valid),
    .req_o      (req)
  );

  i2cmbs_step u_step (
    .st_i  (st_q),
    .req_i (req),
    .st_o  (st_d),
    .res_o (res_d)
  );

  // Advance sequencer state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q.scl   <= 1'b1;
      st_q.sda   <= 1'b1;
      st_q.op    <= OP_TICK;
      st_q.step  <= '0;
      st_q.phase <= '0;
      st_q.tx    <= '0;
      st_q.rx    <= '0;
      st_q.ack   <= 1'b1;
    end else if (fire) begin
      st_q <= st_d;
    end
  end

  // Hold result valid until taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Load result payload
  always_ff @(posedge clk_i) begin
    if (fire) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_res_o   = res_q;

endmodule

// ===== rtl/i2cmbs_checker.sv =====
// Port checker for the I2C master bit sequencer, bound to the top level.
// Depends on i2cmbs_pkg and i2c_master_bit_sequencer_core.
module i2cmbs_checker import i2cmbs_pkg::*; (
  input logic clk_i,
  input logic rst_ni,
  input logic in_valid_i,
  input logic in_ready_o,
  input req_t in_req_i,
  input logic out_valid_o,
  input logic out_ready_i,
  input res_t out_res_o
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_res_o))
    else $error("result changed while stalled");

  // A finished sequence leaves the sequencer idle
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.done_res |-> !out_res_o.busy_res)
    else $error("done reported while still busy");

  // A rejected request only happens while a sequence runs
  a_reject_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.status |-> out_res_o.busy_res)
    else $error("request rejected while idle");

  // Done and reject never come from the same request
  a_done_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_res_o.done_res |-> !out_res_o.status)
    else $error("done and reject together");

endmodule

bind i2c_master_bit_sequencer_core i2cmbs_checker u_i2cmbs_checker (.*);
